// ===== rtl/core/grid_detection_decode_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid detection decoder
// Concurrent assertion wrappers sampled on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_DETECTION_DECODE_ASSERT_SVH
`define GRID_DETECTION_DECODE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define GDD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define GDD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GDD_ASSERT_IMP(label, ante, cons, msg)
`define GDD_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid detection decoder package
// Shared types, register codes and constants for the decoder and its registers.
// ----------------------------------------------------------------------------
package gdd_pkg;

	// Default limits handed to the top level parameters.
	localparam int MAX_GRID_SIDE_DEF = 16;
	localparam int MAX_BOXES_DEF     = 4;
	localparam int MAX_CLASSES_DEF   = 64;

	// Configuration port geometry.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Fixed-point constants: Q4.12 inputs and a reciprocal scaled by two to the thirty.
	localparam int FRAC_W      = 12;
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 31;

	// Register indexes, one word apart on the configuration port.
	typedef enum logic [2:0] {
		REG_GRID_SIDE   = 3'd0,
		REG_BOXES       = 3'd1,
		REG_CLASS_COUNT = 3'd2,
		REG_IMG_WIDTH   = 3'd3,
		REG_IMG_HEIGHT  = 3'd4,
		REG_THRESHOLD   = 3'd5,
		REG_SQUARE_MODE = 3'd6,
		REG_OBJ_ONLY    = 3'd7
	} cfg_reg_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [4:0]         grid_side;
		logic [2:0]         boxes_per_cell;
		logic [6:0]         class_count;
		logic [12:0]        image_width;
		logic [12:0]        image_height;
		logic signed [15:0] prob_threshold;
		logic               square_size_mode;
		logic               objectness_only;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		grid_side:        5'd7,
		boxes_per_cell:   3'd2,
		class_count:      7'd20,
		image_width:      13'd1,
		image_height:     13'd1,
		prob_threshold:   16'sd819,
		square_size_mode: 1'b0,
		objectness_only:  1'b0
	};

	// One input item: a grid cell, a box slot and a class with raw Q4.12 values.
	typedef struct packed {
		logic [3:0]         cell_row;
		logic [3:0]         cell_col;
		logic [1:0]         box_slot;
		logic [5:0]         class_number;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
		logic signed [15:0] width_root;
		logic signed [15:0] height_root;
		logic signed [15:0] objectness;
		logic signed [15:0] class_score;
	} tile_t;

	// One decoded detection.
	typedef struct packed {
		logic               item_valid;
		logic [9:0]         flat_box;
		logic [5:0]         class_id;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] box_width;
		logic signed [31:0] box_height;
		logic signed [15:0] probability;
	} det_t;

endpackage

// ===== rtl/core/gdd_regs.sv =====
// ----------------------------------------------------------------------------
// Grid detection decoder configuration registers
// APB-style register file holding the eight decoder settings.
// ----------------------------------------------------------------------------
module gdd_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gdd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [gdd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [gdd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output gdd_pkg::cfg_t                   cfg
);

	logic              wr_en;
	gdd_pkg::cfg_reg_t reg_sel;
	gdd_pkg::cfg_t     cfg_q;

	// A write transfer completes in the access phase; the port never waits.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = gdd_pkg::cfg_reg_t'(paddr[gdd_pkg::APB_ADDR_W-1:2]);
	assign cfg     = cfg_q;

	// Register writes keep the low bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= gdd_pkg::CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				gdd_pkg::REG_GRID_SIDE:   cfg_q.grid_side        <= pwdata[4:0];
				gdd_pkg::REG_BOXES:       cfg_q.boxes_per_cell   <= pwdata[2:0];
				gdd_pkg::REG_CLASS_COUNT: cfg_q.class_count      <= pwdata[6:0];
				gdd_pkg::REG_IMG_WIDTH:   cfg_q.image_width      <= pwdata[12:0];
				gdd_pkg::REG_IMG_HEIGHT:  cfg_q.image_height     <= pwdata[12:0];
				gdd_pkg::REG_THRESHOLD:   cfg_q.prob_threshold   <= $signed(pwdata[15:0]);
				gdd_pkg::REG_SQUARE_MODE: cfg_q.square_size_mode <= pwdata[0];
				gdd_pkg::REG_OBJ_ONLY:    cfg_q.objectness_only  <= pwdata[0];
			endcase
		end
	end

	// Read data returns the stored bits, zero extended.
	always_comb begin
		unique case (reg_sel)
			gdd_pkg::REG_GRID_SIDE:   prdata = 32'(cfg_q.grid_side);
			gdd_pkg::REG_BOXES:       prdata = 32'(cfg_q.boxes_per_cell);
			gdd_pkg::REG_CLASS_COUNT: prdata = 32'(cfg_q.class_count);
			gdd_pkg::REG_IMG_WIDTH:   prdata = 32'(cfg_q.image_width);
			gdd_pkg::REG_IMG_HEIGHT:  prdata = 32'(cfg_q.image_height);
			gdd_pkg::REG_THRESHOLD:   prdata = {16'd0, cfg_q.prob_threshold};
			gdd_pkg::REG_SQUARE_MODE: prdata = 32'(cfg_q.square_size_mode);
			gdd_pkg::REG_OBJ_ONLY:    prdata = 32'(cfg_q.objectness_only);
		endcase
	end

endmodule

// ===== rtl/core/grid_detection_decode.sv =====
// A result passes through five registered pipeline stages before it is presented.
// Throughput: one item per cycle; the stages only hold back when the output is stalled.
// The widest path is the 32 by 32 bit reciprocal multiply that divides by the grid side.
// Reset empties the pipeline and returns every configuration register to its default.
// ----------------------------------------------------------------------------
// Grid detection decoder
// Turns raw grid-detector values into a flat box index, image-scaled box
// centre and size, and a thresholded class probability.
// ----------------------------------------------------------------------------
`include "grid_detection_decode_assert.svh"

module grid_detection_decode #(
	parameter int MAX_GRID_SIDE = gdd_pkg::MAX_GRID_SIDE_DEF,
	parameter int MAX_BOXES     = gdd_pkg::MAX_BOXES_DEF,
	parameter int MAX_CLASSES   = gdd_pkg::MAX_CLASSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tile_valid,
	output logic                            tile_stall,
	input  gdd_pkg::tile_t                  tile_data,
	output logic                            det_valid,
	input  logic                            det_stall,
	output gdd_pkg::det_t                   det_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gdd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [gdd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [gdd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int RW = gdd_pkg::RECIP_W;
	localparam int RS = gdd_pkg::RECIP_SHIFT;
	localparam int FW = gdd_pkg::FRAC_W;

	gdd_pkg::cfg_t cfg;

	gdd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ------------------------------------------------------------------
	// Reciprocal of the grid side, floor(2^30 / side), from a constant table.
	// ------------------------------------------------------------------
	logic [RW-1:0] rcp_tab [MAX_GRID_SIDE+1];
	logic [RW-1:0] rcp_d;
	logic [RW-1:0] recip_q;

	assign rcp_tab[0] = '0;
	for (genvar g = 1; g <= MAX_GRID_SIDE; g++) begin : g_rcp
		localparam logic [RW-1:0] RcpVal = RW'((64'd1 << RS) / g);
		assign rcp_tab[g] = RcpVal;
	end

	always_comb begin
		rcp_d = '0;
		for (int i = 0; i <= MAX_GRID_SIDE; i++) begin
			if (int'(cfg.grid_side) == i) begin
				rcp_d = rcp_tab[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= '0;
		end else begin
			recip_q <= rcp_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when it is empty or its contents move on.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5      = !v_s5 || !det_stall;
	assign en_s4      = !v_s4 || en_s5;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign tile_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= tile_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: range check, cell offsets, size squares and raw probability.
	// ------------------------------------------------------------------
	logic               side_ok, boxes_ok, cls_ok, in_ok;
	logic signed [17:0] sx_d, sy_d;
	logic signed [31:0] szw_d, szh_d, pr_d;

	assign side_ok  = (cfg.grid_side != '0) && (int'(cfg.grid_side) <= MAX_GRID_SIDE);
	assign boxes_ok = (cfg.boxes_per_cell != '0) && (int'(cfg.boxes_per_cell) <= MAX_BOXES);
	assign cls_ok   = (cfg.class_count != '0) && (int'(cfg.class_count) <= MAX_CLASSES);
	assign in_ok    = side_ok && boxes_ok && cls_ok &&
		({1'b0, tile_data.cell_row} < cfg.grid_side) &&
		({1'b0, tile_data.cell_col} < cfg.grid_side) &&
		({1'b0, tile_data.box_slot} < cfg.boxes_per_cell) &&
		({1'b0, tile_data.class_number} < cfg.class_count);

	// Offset plus the cell position, both in Q4.12.
	assign sx_d = $signed({2'b00, tile_data.cell_col, 12'd0}) + 18'(tile_data.x_offset);
	assign sy_d = $signed({2'b00, tile_data.cell_row, 12'd0}) + 18'(tile_data.y_offset);

	// Size operand: the raw root, or its square in Q8.24 when squaring is on.
	always_comb begin
		if (cfg.square_size_mode) begin
			szw_d = tile_data.width_root * tile_data.width_root;
			szh_d = tile_data.height_root * tile_data.height_root;
		end else begin
			szw_d = 32'(tile_data.width_root);
			szh_d = 32'(tile_data.height_root);
		end
	end

	assign pr_d = tile_data.objectness * tile_data.class_score;

	logic               ok_s1, bare_s1;
	logic [5:0]         cls_s1;
	logic [3:0]         col_s1;
	logic [1:0]         slot_s1;
	logic [8:0]         rs_s1;
	logic signed [17:0] sx_s1, sy_s1;
	logic signed [31:0] szw_s1, szh_s1, pr_s1;
	logic signed [15:0] obj_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ok_s1   <= in_ok;
			bare_s1 <= cfg.objectness_only && (tile_data.class_number == '0);
			cls_s1  <= tile_data.class_number;
			col_s1  <= tile_data.cell_col;
			slot_s1 <= tile_data.box_slot;
			rs_s1   <= 9'(tile_data.cell_row) * 9'(cfg.grid_side);
			sx_s1   <= sx_d;
			sy_s1   <= sy_d;
			szw_s1  <= szw_d;
			szh_s1  <= szh_d;
			pr_s1   <= pr_d;
			obj_s1  <= tile_data.objectness;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: image scaling, probability floor, saturation and threshold.
	// ------------------------------------------------------------------
	logic signed [31:0] nx_d, ny_d;
	logic signed [45:0] bw_d, bh_d;
	logic signed [19:0] p_floor;
	logic signed [15:0] p_sat, p_d;
	logic [12:0]        idx2_d;

	assign nx_d = sx_s1 * $signed({1'b0, cfg.image_width});
	assign ny_d = sy_s1 * $signed({1'b0, cfg.image_height});
	assign bw_d = szw_s1 * $signed({1'b0, cfg.image_width});
	assign bh_d = szh_s1 * $signed({1'b0, cfg.image_height});

	// Dropping the fraction bits of a signed product rounds towards minus infinity.
	assign p_floor = $signed(pr_s1[31:FW]);

	always_comb begin
		if (p_floor > 20'sd32767) begin
			p_sat = 16'sh7FFF;
		end else if (p_floor < -20'sd32768) begin
			p_sat = 16'sh8000;
		end else begin
			p_sat = p_floor[15:0];
		end
		if (bare_s1) begin
			p_d = obj_s1;
		end else if (p_sat > cfg.prob_threshold) begin
			p_d = p_sat;
		end else begin
			p_d = '0;
		end
	end

	assign idx2_d = (13'(rs_s1) + 13'(col_s1)) * 13'(cfg.boxes_per_cell);

	logic               ok_s2;
	logic [5:0]         cls_s2;
	logic [1:0]         slot_s2;
	logic [12:0]        idx_s2;
	logic signed [31:0] nx_s2, ny_s2;
	logic signed [45:0] bw_s2, bh_s2;
	logic signed [15:0] p_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ok_s2   <= ok_s1;
			cls_s2  <= cls_s1;
			slot_s2 <= slot_s1;
			idx_s2  <= idx2_d;
			nx_s2   <= nx_d;
			ny_s2   <= ny_d;
			bw_s2   <= bw_d;
			bh_s2   <= bh_d;
			p_s2    <= p_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: quotient estimate by reciprocal, size rescale and saturation.
	// ------------------------------------------------------------------
	function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
		logic signed [31:0] r;
		if (v > 46'sh0_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -46'sh0_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic signed [63:0] qx_prod, qy_prod;
	logic signed [45:0] bw_sh, bh_sh;

	assign qx_prod = nx_s2 * $signed({1'b0, recip_q});
	assign qy_prod = ny_s2 * $signed({1'b0, recip_q});

	// A squared size carries 24 fraction bits; bring it back to Q20.12.
	assign bw_sh = cfg.square_size_mode ? (bw_s2 >>> FW) : bw_s2;
	assign bh_sh = cfg.square_size_mode ? (bh_s2 >>> FW) : bh_s2;

	logic               ok_s3;
	logic [5:0]         cls_s3;
	logic [9:0]         idx_s3;
	logic signed [31:0] nx_s3, ny_s3, qx_s3, qy_s3, bw_s3, bh_s3;
	logic signed [15:0] p_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ok_s3  <= ok_s2;
			cls_s3 <= cls_s2;
			idx_s3 <= 10'(idx_s2 + 13'(slot_s2));
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			qx_s3  <= $signed(qx_prod[RS +: 32]);
			qy_s3  <= $signed(qy_prod[RS +: 32]);
			bw_s3  <= sat32(bw_sh);
			bh_s3  <= sat32(bh_sh);
			p_s3   <= p_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: remainder of the estimate, which is off by at most one.
	// ------------------------------------------------------------------
	logic signed [37:0] qdx, qdy;
	logic signed [33:0] side34;

	assign side34 = $signed({29'd0, cfg.grid_side});
	assign qdx    = qx_s3 * $signed({1'b0, cfg.grid_side});
	assign qdy    = qy_s3 * $signed({1'b0, cfg.grid_side});

	logic               ok_s4;
	logic [5:0]         cls_s4;
	logic [9:0]         idx_s4;
	logic signed [31:0] qx_s4, qy_s4, bw_s4, bh_s4;
	logic signed [33:0] rx_s4, ry_s4;
	logic signed [15:0] p_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ok_s4  <= ok_s3;
			cls_s4 <= cls_s3;
			idx_s4 <= idx_s3;
			qx_s4  <= qx_s3;
			qy_s4  <= qy_s3;
			rx_s4  <= 34'(nx_s3) - 34'(qdx);
			ry_s4  <= 34'(ny_s3) - 34'(qdy);
			bw_s4  <= bw_s3;
			bh_s4  <= bh_s3;
			p_s4   <= p_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: floor correction and the output register.
	// The centre quotient stays within 31 bits, so it needs no saturation.
	// ------------------------------------------------------------------
	logic signed [31:0] cx_d, cy_d;
	gdd_pkg::det_t      det_d, det_s5;

	always_comb begin
		if (rx_s4 < 34'sd0) begin
			cx_d = qx_s4 - 32'sd1;
		end else if (rx_s4 >= side34) begin
			cx_d = qx_s4 + 32'sd1;
		end else begin
			cx_d = qx_s4;
		end
		if (ry_s4 < 34'sd0) begin
			cy_d = qy_s4 - 32'sd1;
		end else if (ry_s4 >= side34) begin
			cy_d = qy_s4 + 32'sd1;
		end else begin
			cy_d = qy_s4;
		end
	end

	// Out-of-range items report zeros but keep their class number.
	always_comb begin
		det_d.item_valid = ok_s4;
		det_d.class_id   = cls_s4;
		if (ok_s4) begin
			det_d.flat_box    = idx_s4;
			det_d.center_x    = cx_d;
			det_d.center_y    = cy_d;
			det_d.box_width   = bw_s4;
			det_d.box_height  = bh_s4;
			det_d.probability = p_s4;
		end else begin
			det_d.flat_box    = '0;
			det_d.center_x    = '0;
			det_d.center_y    = '0;
			det_d.box_width   = '0;
			det_d.box_height  = '0;
			det_d.probability = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			det_s5 <= det_d;
		end
	end

	assign det_valid = v_s5;
	assign det_data  = det_s5;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	logic rem_x_ok, rem_y_ok, det_zero, thr_skip;

	assign rem_x_ok = (rx_s4 + side34 >= 34'sd0) && (rx_s4 < side34 + side34);
	assign rem_y_ok = (ry_s4 + side34 >= 34'sd0) && (ry_s4 < side34 + side34);
	assign det_zero = (det_data.flat_box == '0) && (det_data.center_x == '0) &&
		(det_data.center_y == '0) && (det_data.box_width == '0) &&
		(det_data.box_height == '0) && (det_data.probability == '0);
	assign thr_skip = cfg.objectness_only && (det_data.class_id == '0);

	`GDD_ASSERT_IMP(a_rem_range, v_s4 && ok_s4, rem_x_ok && rem_y_ok, "quotient estimate off")
	`GDD_ASSERT_IMP(a_invalid_zero, det_valid && !det_data.item_valid, det_zero, "bad zeroing")
	`GDD_ASSERT_IMP(a_prob_thr, det_valid && det_data.item_valid && (det_data.probability != '0) && !thr_skip, det_data.probability > cfg.prob_threshold, "threshold")
	`GDD_ASSERT_NXT(a_stage_move, v_s1 && en_s2, v_s2, "item lost between stage one and stage two")

endmodule

// ===== verif/tb_grid_detection_decode.sv =====
// ----------------------------------------------------------------------------
// Grid detection decoder testbench
// Drives grid-cell items through the decoder and checks every decoded box
// against its typed result or a behavioural decoder kept in step with the
// register settings. A directed table comes first, then phases of random
// items under changing settings, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_grid_detection_decode;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 125;
	localparam int DRAIN_CYCLES = 10;

	// One row of the directed table; the decoded box is typed in where it is obvious.
	typedef struct {
		gdd_pkg::tile_t item;
		bit             typed;
		gdd_pkg::det_t  want;
	} plan_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           tile_valid;
	logic                           tile_stall;
	gdd_pkg::tile_t                 tile_data;
	logic                           det_valid;
	logic                           det_stall = 1'b0;
	gdd_pkg::det_t                  det_data;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [gdd_pkg::APB_ADDR_W-1:0] paddr;
	logic [gdd_pkg::APB_DATA_W-1:0] pwdata;
	logic [gdd_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	gdd_pkg::cfg_t cfg = gdd_pkg::CFG_RESET;
	gdd_pkg::det_t due_dets[$];
	plan_row_t     plan[$];
	int            bad_dets = 0;
	bit            quiet = 1'b0;
	int            stall_run = 0;

	grid_detection_decode u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tile_valid (tile_valid),
		.tile_stall (tile_stall),
		.tile_data  (tile_data),
		.det_valid  (det_valid),
		.det_stall  (det_stall),
		.det_data   (det_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#10_000_000;
		$display("tb_grid_detection_decode NOT OK");
		$finish;
	end

	// Mostly short gaps, now and then a long one; none at all in quiet phases.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic longint div_floor(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) begin
			q--;
		end
		return q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic bit cfg_ok();
		return cfg.grid_side >= 1 && cfg.grid_side <= gdd_pkg::MAX_GRID_SIDE_DEF &&
			cfg.boxes_per_cell >= 1 && cfg.boxes_per_cell <= gdd_pkg::MAX_BOXES_DEF &&
			cfg.class_count >= 1 && cfg.class_count <= gdd_pkg::MAX_CLASSES_DEF;
	endfunction

	// Box size scaled to the image, squared first in square-size mode.
	function automatic longint scaled_size(longint root, longint scale);
		longint v;
		if (cfg.square_size_mode) begin
			v = (root * root * scale) >>> gdd_pkg::FRAC_W;
		end else begin
			v = root * scale;
		end
		return clamp(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	// Decodes one item under the current register settings.
	function automatic gdd_pkg::det_t decode_tile(gdd_pkg::tile_t t);
		gdd_pkg::det_t d;
		longint        side, cx, cy, bw, bh, p, obj, score, idx;
		d = '0;
		d.class_id = t.class_number;
		if (!cfg_ok() || t.cell_row >= cfg.grid_side || t.cell_col >= cfg.grid_side ||
				t.box_slot >= cfg.boxes_per_cell || t.class_number >= cfg.class_count) begin
			return d;
		end
		side = longint'(cfg.grid_side);
		idx = (longint'(t.cell_row) * side + longint'(t.cell_col)) *
			longint'(cfg.boxes_per_cell) + longint'(t.box_slot);
		cx = div_floor((longint'(t.x_offset) + longint'(t.cell_col) * 4096) *
			longint'(cfg.image_width), side);
		cy = div_floor((longint'(t.y_offset) + longint'(t.cell_row) * 4096) *
			longint'(cfg.image_height), side);
		cx = clamp(cx, -64'sd2147483648, 64'sd2147483647);
		cy = clamp(cy, -64'sd2147483648, 64'sd2147483647);
		bw = scaled_size(longint'(t.width_root), longint'(cfg.image_width));
		bh = scaled_size(longint'(t.height_root), longint'(cfg.image_height));
		obj = longint'(t.objectness);
		score = longint'(t.class_score);
		// In objectness-only mode class 0 reports the bare objectness.
		if (cfg.objectness_only && t.class_number == 6'd0) begin
			p = obj;
		end else begin
			p = clamp(div_floor(obj * score, 4096), -32768, 32767);
			if (!(p > longint'(cfg.prob_threshold))) begin
				p = 0;
			end
		end
		d.item_valid = 1'b1;
		d.flat_box = idx[9:0];
		d.center_x = cx[31:0];
		d.center_y = cy[31:0];
		d.box_width = bw[31:0];
		d.box_height = bh[31:0];
		d.probability = p[15:0];
		return d;
	endfunction

	function automatic gdd_pkg::tile_t mk_tile(int row, int col, int slot, int cls, int xo,
			int yo, int wr, int hr, int obj, int score);
		gdd_pkg::tile_t t;
		t.cell_row = 4'(row);
		t.cell_col = 4'(col);
		t.box_slot = 2'(slot);
		t.class_number = 6'(cls);
		t.x_offset = 16'(xo);
		t.y_offset = 16'(yo);
		t.width_root = 16'(wr);
		t.height_root = 16'(hr);
		t.objectness = 16'(obj);
		t.class_score = 16'(score);
		return t;
	endfunction

	function automatic gdd_pkg::det_t mk_det(bit v, int idx, int cls, int cx, int cy, int bw,
			int bh, int p);
		gdd_pkg::det_t d;
		d.item_valid = v;
		d.flat_box = 10'(idx);
		d.class_id = 6'(cls);
		d.center_x = cx;
		d.center_y = cy;
		d.box_width = bw;
		d.box_height = bh;
		d.probability = 16'(p);
		return d;
	endfunction

	function automatic void add_row(gdd_pkg::tile_t t, bit typed, gdd_pkg::det_t want);
		plan_row_t r;
		r.item = t;
		r.typed = typed;
		r.want = want;
		plan.push_back(r);
	endfunction

	// Raw Q4.12 value leaning towards the extremes and small magnitudes.
	function automatic logic [15:0] raw_q();
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'h1000;
			5, 6: return 16'($urandom_range(0, 16383) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly items that land inside the configured grid, some that do not.
	function automatic gdd_pkg::tile_t random_tile();
		gdd_pkg::tile_t t;
		bit             shaped;
		shaped = cfg_ok() && ($urandom_range(0, 7) != 0);
		if (shaped) begin
			t.cell_row = 4'($urandom_range(0, int'(cfg.grid_side) - 1));
			t.cell_col = 4'($urandom_range(0, int'(cfg.grid_side) - 1));
			t.box_slot = 2'($urandom_range(0, int'(cfg.boxes_per_cell) - 1));
			if (cfg.objectness_only && $urandom_range(0, 3) == 0) begin
				t.class_number = 6'd0;
			end else begin
				t.class_number = 6'($urandom_range(0, int'(cfg.class_count) - 1));
			end
		end else begin
			t.cell_row = 4'($urandom);
			t.cell_col = 4'($urandom);
			t.box_slot = 2'($urandom);
			t.class_number = 6'($urandom);
		end
		t.x_offset = raw_q();
		t.y_offset = raw_q();
		t.width_root = raw_q();
		t.height_root = raw_q();
		t.objectness = raw_q();
		t.class_score = raw_q();
		// Unit objectness with a score just below, at or just above the threshold.
		if ($urandom_range(0, 7) == 0) begin
			t.objectness = 16'sd4096;
			t.class_score = cfg.prob_threshold + 16'($urandom_range(0, 2)) - 16'sd1;
		end
		return t;
	endfunction

	function automatic logic [12:0] pick_scale();
		case ($urandom_range(0, 15))
			0: return 13'd0;
			1: return 13'd8191;
			2, 3, 4: return 13'($urandom_range(1, 16));
			default: return 13'($urandom_range(1, 4096));
		endcase
	endfunction

	// Register settings for one phase: minima, maxima, a broken one, then random.
	function automatic gdd_pkg::cfg_t pick_config(int k);
		gdd_pkg::cfg_t c;
		c.grid_side = 5'($urandom_range(1, 16));
		c.boxes_per_cell = 3'($urandom_range(1, 4));
		c.class_count = 7'($urandom_range(1, 64));
		c.image_width = pick_scale();
		c.image_height = pick_scale();
		if ($urandom_range(0, 1) != 0) begin
			c.prob_threshold = 16'($urandom);
		end else begin
			c.prob_threshold = 16'($urandom_range(0, 8192) - 4096);
		end
		c.square_size_mode = 1'($urandom);
		c.objectness_only = 1'($urandom);
		case (k)
			0: c = '{5'd1, 3'd1, 7'd1, 13'd1, 13'd1, 16'sh8000, 1'b0, 1'b0};
			1: c = '{5'd16, 3'd4, 7'd64, 13'd8191, 13'd8191, 16'sh7fff, 1'b1, 1'b1};
			2: begin
				case ($urandom_range(0, 2))
					0: c.grid_side = ($urandom_range(0, 1) != 0) ? 5'd0 :
						5'($urandom_range(17, 31));
					1: c.boxes_per_cell = ($urandom_range(0, 1) != 0) ? 3'd0 :
						3'($urandom_range(5, 7));
					default: c.class_count = ($urandom_range(0, 1) != 0) ? 7'd0 :
						7'($urandom_range(65, 127));
				endcase
			end
			default: ;
		endcase
		return c;
	endfunction

	// One register write: setup cycle, then access cycle until pready.
	task automatic cfg_write(input gdd_pkg::cfg_reg_t r, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input gdd_pkg::cfg_t c);
		cfg_write(gdd_pkg::REG_GRID_SIDE, 32'(c.grid_side));
		cfg_write(gdd_pkg::REG_BOXES, 32'(c.boxes_per_cell));
		cfg_write(gdd_pkg::REG_CLASS_COUNT, 32'(c.class_count));
		cfg_write(gdd_pkg::REG_IMG_WIDTH, 32'(c.image_width));
		cfg_write(gdd_pkg::REG_IMG_HEIGHT, 32'(c.image_height));
		cfg_write(gdd_pkg::REG_THRESHOLD, {16'd0, c.prob_threshold});
		cfg_write(gdd_pkg::REG_SQUARE_MODE, 32'(c.square_size_mode));
		cfg_write(gdd_pkg::REG_OBJ_ONLY, 32'(c.objectness_only));
		cfg = c;
	endtask

	// Offers one item after a random gap and records its decoded box on transfer.
	task automatic send_tile(input gdd_pkg::tile_t t, input bit typed,
			input gdd_pkg::det_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tile_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tile_valid <= 1'b1;
		tile_data <= t;
		do @(posedge clk); while (tile_stall);
		due_dets.push_back(typed ? want : decode_tile(t));
	endtask

	// Stops offering items and waits until every decoded box has come back.
	task automatic settle();
		tile_valid <= 1'b0;
		while (due_dets.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Output stalls: runs of random length with stall-free spans between them.
	always @(posedge clk) begin
		int n;
		if (stall_run > 0) begin
			stall_run--;
		end else if (det_stall) begin
			det_stall <= 1'b0;
			stall_run = $urandom_range(0, 20);
		end else begin
			n = pick_gap();
			det_stall <= (n > 0);
			stall_run = (n > 0) ? n - 1 : 0;
		end
	end

	// Every output transfer is checked against the oldest decoded box still due.
	always @(posedge clk) begin
		gdd_pkg::det_t want;
		if (arst_n && det_valid && !det_stall) begin
			if (due_dets.size() == 0) begin
				bad_dets++;
				if (bad_dets <= 10) begin
					$display("unexpected det: box %0d class %0d", det_data.flat_box,
						det_data.class_id);
				end
			end else begin
				want = due_dets.pop_front();
				if (det_data.item_valid !== want.item_valid ||
						det_data.flat_box !== want.flat_box ||
						det_data.class_id !== want.class_id ||
						det_data.center_x !== want.center_x ||
						det_data.center_y !== want.center_y ||
						det_data.box_width !== want.box_width ||
						det_data.box_height !== want.box_height ||
						det_data.probability !== want.probability) begin
					bad_dets++;
					if (bad_dets <= 10) begin
						$display("det mismatch at %0t", $realtime);
						$display("  want v%0b i%0d c%0d x%0d y%0d w%0d h%0d p%0d",
							want.item_valid, want.flat_box, want.class_id,
							want.center_x, want.center_y, want.box_width,
							want.box_height, want.probability);
						$display("  got  v%0b i%0d c%0d x%0d y%0d w%0d h%0d p%0d",
							det_data.item_valid, det_data.flat_box, det_data.class_id,
							det_data.center_x, det_data.center_y, det_data.box_width,
							det_data.box_height, det_data.probability);
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		tile_valid = 1'b0;
		tile_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// Directed table. Typed results hold for the reset settings only.
		add_row(mk_tile(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_det(1, 0, 0, 0, 0, 0, 0, 0));
		// Row, column, slot or class out of range: everything but the class is cleared.
		add_row(mk_tile(7, 0, 0, 5, 4096, 4096, 4096, 4096, 4096, 4096), 1'b1,
			mk_det(0, 0, 5, 0, 0, 0, 0, 0));
		add_row(mk_tile(0, 15, 0, 3, -1, -1, -1, -1, -1, -1), 1'b1,
			mk_det(0, 0, 3, 0, 0, 0, 0, 0));
		add_row(mk_tile(0, 0, 3, 1, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1,
			mk_det(0, 0, 1, 0, 0, 0, 0, 0));
		add_row(mk_tile(0, 0, 0, 63, 100, 100, 100, 100, 4096, 4096), 1'b1,
			mk_det(0, 0, 63, 0, 0, 0, 0, 0));
		// Last cell and last slot of the default grid.
		add_row(mk_tile(6, 6, 1, 19, 0, 0, 0, 0, 0, 0), 1'b1,
			mk_det(1, 97, 19, 3510, 3510, 0, 0, 0));
		// Probability saturates high, and saturates low to fall under the threshold.
		add_row(mk_tile(0, 0, 0, 0, 0, 0, 0, 0, -32768, -32768), 1'b1,
			mk_det(1, 0, 0, 0, 0, 0, 0, 32767));
		add_row(mk_tile(0, 0, 0, 2, 0, 0, 0, 0, 32767, -32768), 1'b1,
			mk_det(1, 0, 2, 0, 0, 0, 0, 0));
		add_row(mk_tile(3, 4, 1, 7, 32767, -32768, -32768, 32767, 32767, 32767), 1'b0, '0);
		// Probability equal to the threshold, then just above it.
		add_row(mk_tile(5, 2, 0, 9, -32768, 32767, 32767, -32768, 4096, 819), 1'b0, '0);
		add_row(mk_tile(5, 2, 1, 9, 1234, -1234, 2048, -2048, 4096, 820), 1'b0, '0);
		add_row(mk_tile(6, 6, 1, 19, 32767, 32767, 32767, 32767, 32767, 32767), 1'b0, '0);
		add_row(mk_tile(0, 0, 0, 0, -32768, -32768, -32768, -32768, -32768, 1), 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The table runs at the reset settings, then again with the widest settings.
		foreach (plan[i]) begin
			send_tile(plan[i].item, plan[i].typed, plan[i].want);
		end
		settle();
		set_config('{5'd16, 3'd4, 7'd64, 13'd8191, 13'd8191, 16'sh8000, 1'b1, 1'b1});
		foreach (plan[i]) begin
			send_tile(plan[i].item, 1'b0, '0);
		end

		// Random phases, each under its own register settings.
		for (int k = 0; k < PHASES; k++) begin
			settle();
			quiet = 1'b0;
			set_config(pick_config(k));
			quiet = (k % 4 == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_tile(random_tile(), 1'b0, '0);
			end
		end
		quiet = 1'b0;
		settle();

		if (bad_dets == 0) begin
			$display("tb_grid_detection_decode OK");
		end else begin
			$display("tb_grid_detection_decode NOT OK");
		end
		$finish;
	end

endmodule
